// ===== src/khc_pkg.sv =====
// Shared types and constants for the k-mer histogram counter.
`default_nettype none

package khc_pkg;

    // Default sizing handed to the top level parameters, and fixed result field widths
    localparam int MAX_K_DEF      = 8;
    localparam int COUNT_BITS_DEF = 32;
    localparam int TOTAL_BITS     = 40;
    localparam int COUNT_OUT_BITS = 32;

    // Request kinds carried on tuser
    localparam logic [1:0] ACT_SEQ   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_KLEN = 1'b0;
    localparam logic CFG_ALL  = 1'b1;

    localparam logic [3:0] KLEN_RESET = 4'd4;

    // Character codes
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_CASE_MASK = 8'hDF;
    localparam logic [7:0] CH_A         = 8'h41;
    localparam logic [7:0] CH_C         = 8'h43;
    localparam logic [7:0] CH_G         = 8'h47;
    localparam logic [7:0] CH_T         = 8'h54;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_FIN
    } t_state;

    // Counter memory port control
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_ram_ctl;

    // Length total control
    typedef struct packed {
        logic inc;
        logic clr;
    } t_tot_ctl;

    // Result hand-off to the output register
    typedef struct packed {
        logic load;
        logic start;
        logic is_read;
    } t_res_ctl;

endpackage

`default_nettype wire

// ===== src/khc_cnt_ram.sv =====
// Counter memory with a saturating read-modify-write port and clear writes.
`default_nettype none

module khc_cnt_ram #(
    parameter int              AW    = 17,
    parameter int              CW    = 32,
    parameter longint unsigned DEPTH = 87380
) (
    input  wire                 i_clk,
    input  khc_pkg::t_ram_ctl   i_ctl,
    input  wire [AW-1:0]        i_addr,
    output logic [CW-1:0]       o_rdata
);

    logic [CW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_rdata;
    logic [CW-1:0] n_inc;

    // Saturating increment of the word read in the previous cycle
    assign n_inc = (&r_rdata) ? r_rdata : r_rdata + CW'(1);

    // Write back or clear, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_ctl.clr ? '0 : n_inc;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/khc_totals.sv =====
// Per-length saturating totals of counted k-mers.
`default_nettype none

module khc_totals #(
    parameter int MAX_K = 8,
    parameter int TIW   = 3
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  khc_pkg::t_tot_ctl                i_ctl,
    input  wire [TIW-1:0]                    i_idx,
    output logic [khc_pkg::TOTAL_BITS-1:0]   o_total
);

    logic [khc_pkg::TOTAL_BITS-1:0] r_tot [MAX_K];

    assign o_total = r_tot[i_idx];

    // Clear all, or bump the selected total up to its ceiling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int i = 0; i < MAX_K; i++) begin
                r_tot[i] <= '0;
            end
        end else if (i_ctl.inc && !(&r_tot[i_idx])) begin
            r_tot[i_idx] <= r_tot[i_idx] + khc_pkg::TOTAL_BITS'(1);
        end
    end

endmodule

`default_nettype wire

// ===== src/khc_ctrl.sv =====
// Sequencer: byte parsing, window and run state, memory sweep and bump loop.
`default_nettype none

module khc_ctrl #(
    parameter int              MAX_K = 8,
    parameter int              LW    = 4,
    parameter int              KW    = 16,
    parameter int              AW    = 17,
    parameter int              TIW   = 3,
    parameter longint unsigned DEPTH = 87380
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire [3:0]           i_cfg_data,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire [31:0]          i_s_tdata,
    input  wire [1:0]           i_s_tuser,
    input  wire                 i_out_free,
    output khc_pkg::t_ram_ctl   o_ram,
    output logic [AW-1:0]       o_addr,
    output khc_pkg::t_tot_ctl   o_tot,
    output logic [TIW-1:0]      o_tot_idx,
    output khc_pkg::t_res_ctl   o_res
);

    khc_pkg::t_state r_state, n_state;
    logic [3:0]    r_klen;
    logic          r_all;
    logic [KW-1:0] r_win, n_win;
    logic [LW-1:0] r_run, n_run;
    logic          r_hdr, n_hdr;
    logic [KW-1:0] r_key, n_key;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_last, n_last;
    logic [LW-1:0] r_rlen, n_rlen;
    logic          r_start, n_start;
    logic          r_is_read, n_is_read;
    logic          r_reply, n_reply;
    logic [AW-1:0] r_sweep, n_sweep;

    // Clamp a length field into 1..MAX_K
    function automatic logic [LW-1:0] f_clamp(input logic [3:0] v);
        logic [LW-1:0] r;
        if (v == 4'd0) begin
            r = LW'(1);
        end else if (32'(v) > MAX_K) begin
            r = LW'(MAX_K);
        end else begin
            r = LW'(v);
        end
        return r;
    endfunction

    // Start of the table for length len: 4 + 16 + ... + 4^(len-1)
    function automatic logic [AW-1:0] f_base(input logic [LW-1:0] len);
        logic [AW-1:0] b;
        b = '0;
        for (int j = 1; j < MAX_K; j++) begin
            if (j < 32'(len)) begin
                b[2*j] = 1'b1;
            end
        end
        return b;
    endfunction

    // Keep the low 2*len bits of a code
    function automatic logic [KW-1:0] f_mask(input logic [LW-1:0] len);
        logic [KW-1:0] m;
        for (int b = 0; b < KW; b++) begin
            m[b] = (b < 2 * 32'(len));
        end
        return m;
    endfunction

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= khc_pkg::KLEN_RESET;
            r_all  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                khc_pkg::CFG_KLEN: r_klen <= i_cfg_data;
                khc_pkg::CFG_ALL:  r_all  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // State register; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= khc_pkg::ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_run   <= '0;
            r_hdr   <= 1'b0;
            r_reply <= 1'b0;
            r_sweep <= '0;
        end else begin
            r_win   <= n_win;
            r_run   <= n_run;
            r_hdr   <= n_hdr;
            r_reply <= n_reply;
            r_sweep <= n_sweep;
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_cur     <= n_cur;
        r_last    <= n_last;
        r_rlen    <= n_rlen;
        r_start   <= n_start;
        r_is_read <= n_is_read;
    end

    // Next state and outputs
    always_comb begin
        logic [7:0]    sym;
        logic [7:0]    sym_uc;
        logic          is_base;
        logic [1:0]    code;
        logic [LW-1:0] run_inc;
        logic [LW-1:0] k;
        logic [KW-1:0] win_sh;

        sym    = i_s_tdata[7:0];
        sym_uc = sym & khc_pkg::CH_CASE_MASK;
        k      = f_clamp(r_klen);

        // Decode a base letter of either case
        is_base = 1'b1;
        code    = khc_pkg::BASE_A;
        case (sym_uc)
            khc_pkg::CH_A: code = khc_pkg::BASE_A;
            khc_pkg::CH_C: code = khc_pkg::BASE_C;
            khc_pkg::CH_G: code = khc_pkg::BASE_G;
            khc_pkg::CH_T: code = khc_pkg::BASE_T;
            default:       is_base = 1'b0;
        endcase
        win_sh  = (r_win << 2) | KW'(code);
        run_inc = (32'(r_run) < MAX_K) ? r_run + LW'(1) : r_run;

        n_state   = r_state;
        n_win     = r_win;
        n_run     = r_run;
        n_hdr     = r_hdr;
        n_key     = r_key;
        n_cur     = r_cur;
        n_last    = r_last;
        n_rlen    = r_rlen;
        n_start   = r_start;
        n_is_read = r_is_read;
        n_reply   = r_reply;
        n_sweep   = r_sweep;

        o_s_tready = 1'b0;
        o_ram      = '0;
        o_tot      = '0;
        o_res      = '{load: 1'b0, start: r_start, is_read: r_is_read};
        o_addr     = f_base(r_cur) + AW'(r_key & f_mask(r_cur));
        o_tot_idx  = (r_state == khc_pkg::ST_FIN) ? TIW'(r_rlen - LW'(1))
                                                  : TIW'(r_cur - LW'(1));

        unique case (r_state)
            // Zero the counter memory one word a cycle
            khc_pkg::ST_SWEEP: begin
                o_ram.wr  = 1'b1;
                o_ram.clr = 1'b1;
                o_addr    = r_sweep;
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == AW'(DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = r_reply ? khc_pkg::ST_FIN : khc_pkg::ST_IDLE;
                end
            end

            // Take a request and update the parse state
            khc_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_rlen    = f_clamp(i_s_tdata[11:8]);
                    n_start   = 1'b0;
                    n_is_read = 1'b0;
                    n_state   = khc_pkg::ST_FIN;
                    case (i_s_tuser)
                        khc_pkg::ACT_SEQ: begin
                            if (r_hdr) begin
                                if (sym == khc_pkg::CH_NL) begin
                                    n_hdr = 1'b0;
                                end
                            end else if (sym == khc_pkg::CH_GT) begin
                                n_run   = '0;
                                n_hdr   = 1'b1;
                                n_start = 1'b1;
                            end else if (sym[6]) begin
                                if (!is_base) begin
                                    n_run = '0;
                                end else begin
                                    n_win = win_sh;
                                    n_key = win_sh;
                                    n_run = run_inc;
                                    if (r_all) begin
                                        n_cur   = LW'(1);
                                        n_last  = (run_inc < k) ? run_inc : k;
                                        n_state = khc_pkg::ST_RD;
                                    end else if (run_inc >= k) begin
                                        n_cur   = k;
                                        n_last  = k;
                                        n_state = khc_pkg::ST_RD;
                                    end
                                end
                            end
                        end
                        khc_pkg::ACT_READ: begin
                            n_key     = KW'(i_s_tdata[27:12]);
                            n_cur     = f_clamp(i_s_tdata[11:8]);
                            n_is_read = 1'b1;
                            n_state   = khc_pkg::ST_RD;
                        end
                        khc_pkg::ACT_CLEAR: begin
                            o_tot.clr = 1'b1;
                            n_reply   = 1'b1;
                            n_sweep   = '0;
                            n_state   = khc_pkg::ST_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end

            // Read the counter of the current length
            khc_pkg::ST_RD: begin
                o_ram.rd = 1'b1;
                n_state  = r_is_read ? khc_pkg::ST_FIN : khc_pkg::ST_WR;
            end

            // Write back the bumped counter and advance the length
            khc_pkg::ST_WR: begin
                o_ram.wr  = 1'b1;
                o_tot.inc = 1'b1;
                if (r_cur == r_last) begin
                    n_state = khc_pkg::ST_FIN;
                end else begin
                    n_cur   = r_cur + LW'(1);
                    n_state = khc_pkg::ST_RD;
                end
            end

            // Hand the result over once the output register frees up
            khc_pkg::ST_FIN: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_reply    = 1'b0;
                    n_state    = khc_pkg::ST_IDLE;
                end
            end

            default: n_state = khc_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/kmer_histogram_counter_unit.sv =====
// Top level of the k-mer histogram counter: sequencer, counter memory, totals.
//
// Channel   Dir  Handshake               Content
// s (in)    in   i_s_tvalid/o_s_tready    tuser action, tdata symbol/length/index
// m (out)   out  o_m_tvalid/i_m_tready    tdata count/total, tuser record start
// cfg       in   i_cfg_valid/o_cfg_ready  register index and value
//
// A request occupies the block on the single counter memory port until its result
// is handed on: a read is one memory read, a sequence byte bumps n counters
// (n up to MAX_K), each bump being a read then a write-back of one memory word.
// A clear, and reset, sweep the memory one word a cycle: (4^(MAX_K+1)-4)/3 words,
// 87380 at MAX_K = 8, with o_s_tready low; configuration writes are taken throughout.
// The output register holds a result while i_m_tready is low; the next request
// is taken meanwhile and its own result waits until the register is free.
`default_nettype none

module kmer_histogram_counter_unit #(
    parameter int MAX_K      = khc_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = khc_pkg::COUNT_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_index,   // 0 kmer_length, 1 all_lengths
    input  wire [3:0]    i_cfg_data,
    // Requests
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire [31:0]   i_s_tdata,     // [7:0] symbol, [11:8] read_length,
                                        // [27:12] read_index, [31:28] zero
    input  wire [1:0]    i_s_tuser,     // [1:0] action
    // Results
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [71:0]  o_m_tdata,     // [31:0] count_value, [71:32] length_total
    output logic [0:0]   o_m_tuser      // [0] record_start
);

    localparam int              LW    = $clog2(MAX_K + 1);
    localparam int              KW    = 2 * MAX_K;
    localparam int              AW    = 2 * MAX_K + 1;
    localparam int              TIW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam longint unsigned DEPTH =
        ((64'd1 << (2 * (MAX_K + 1))) - 64'd4) / 64'd3;

    khc_pkg::t_ram_ctl ram_ctl;
    khc_pkg::t_tot_ctl tot_ctl;
    khc_pkg::t_res_ctl res_ctl;
    logic [AW-1:0]     ram_addr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [TIW-1:0]    tot_idx;
    logic [khc_pkg::TOTAL_BITS-1:0] tot_value;
    logic              out_free;
    logic [63:0]       rd_wide;
    logic [khc_pkg::COUNT_OUT_BITS-1:0] count_sat;

    logic                                r_out_valid;
    logic [khc_pkg::COUNT_OUT_BITS-1:0]  r_count;
    logic [khc_pkg::TOTAL_BITS-1:0]      r_total;
    logic                                r_rec;

    khc_ctrl #(
        .MAX_K (MAX_K),
        .LW    (LW),
        .KW    (KW),
        .AW    (AW),
        .TIW   (TIW),
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_out_free  (out_free),
        .o_ram       (ram_ctl),
        .o_addr      (ram_addr),
        .o_tot       (tot_ctl),
        .o_tot_idx   (tot_idx),
        .o_res       (res_ctl)
    );

    khc_cnt_ram #(
        .AW    (AW),
        .CW    (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_addr  (ram_addr),
        .o_rdata (ram_rdata)
    );

    khc_totals #(
        .MAX_K (MAX_K),
        .TIW   (TIW)
    ) u_totals (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tot_ctl),
        .i_idx   (tot_idx),
        .o_total (tot_value)
    );

    // Clip the counter read to the 32-bit result field
    assign rd_wide   = 64'(ram_rdata);
    assign count_sat = (rd_wide > 64'h0000_0000_FFFF_FFFF) ? '1
                                                           : rd_wide[31:0];

    assign out_free = !r_out_valid || i_m_tready;

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (res_ctl.load) begin
            r_count <= res_ctl.is_read ? count_sat : '0;
            r_total <= tot_value;
            r_rec   <= res_ctl.start;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_total, r_count};
    assign o_m_tuser  = r_rec;

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_ctl.load |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending result");

    // One request at a time: busy in the cycle after a request is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while the previous one is in work");

    // No request is taken and no total is bumped while the memory is being cleared
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.clr |-> (!o_s_tready && !tot_ctl.inc))
        else $error("request or bump during memory clear");

endmodule

`default_nettype wire

// ===== sim/khc_checker.sv =====
// Checker for the k-mer histogram counter: tracks the tables and compares every result.
`timescale 1ns / 100ps

module khc_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire          i_cfg_index,   // 0 kmer_length, 1 all_lengths
    input  wire [3:0]    i_cfg_data,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire [31:0]   i_s_tdata,     // [7:0] symbol, [11:8] read_length,
                                        // [27:12] read_index, [31:28] zero
    input  wire [1:0]    i_s_tuser,     // [1:0] action
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire [71:0]   i_m_tdata,     // [31:0] count_value, [71:32] length_total
    input  wire [0:0]    i_m_tuser,     // [0] record_start
    output int           o_error_count,
    output int           o_reports_due
);

    localparam int MAX_K = khc_pkg::MAX_K_DEF;
    localparam int STORE_WORDS = ((4 ** (MAX_K + 1)) - 4) / 3;
    localparam logic [khc_pkg::COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
    localparam logic [khc_pkg::TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [khc_pkg::COUNT_OUT_BITS-1:0] count_value;
        logic [khc_pkg::TOTAL_BITS-1:0]     length_total;
        logic                               record_start;
    } t_count_report;

    // Tracked copy of the block's state and settings
    logic [khc_pkg::COUNT_BITS_DEF-1:0] hist_counts [int];
    logic [khc_pkg::TOTAL_BITS-1:0]     len_totals [MAX_K];
    logic [2*MAX_K-1:0]                 base_window;
    int                                 run_bases;
    logic                               skipping_header;
    logic [3:0]                         kmer_len_reg;
    logic                               all_len_reg;

    t_count_report reports_due [$];
    int            mismatches = 0;

    function automatic int clamp_length(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (int'(v) > MAX_K) return MAX_K;
        return int'(v);
    endfunction

    function automatic int table_start(input int len);
        return ((1 << (2 * len)) - 4) / 3;
    endfunction

    function automatic logic [khc_pkg::COUNT_BITS_DEF-1:0] counter_at(input int addr);
        if (addr < STORE_WORDS && hist_counts.exists(addr)) return hist_counts[addr];
        return '0;
    endfunction

    // Increment the counter of the len-mer ending at the newest base, and its total
    task automatic bump_length(input int len);
        int addr;
        logic [khc_pkg::COUNT_BITS_DEF-1:0] cur;
        addr = table_start(len) + (int'(base_window) & ((1 << (2 * len)) - 1));
        cur = counter_at(addr);
        if (addr < STORE_WORDS && cur != COUNT_MAX) hist_counts[addr] = cur + 1'b1;
        if (len_totals[len-1] != TOTAL_MAX) len_totals[len-1] = len_totals[len-1] + 1'b1;
    endtask

    // Apply one text byte; flag a record start
    task automatic feed_symbol(input logic [7:0] sym, output logic flag);
        int code;
        int k;
        int top;
        flag = 1'b0;
        code = -1;
        k = clamp_length(kmer_len_reg);
        if (skipping_header) begin
            if (sym == khc_pkg::CH_NL) skipping_header = 1'b0;
        end else if (sym == khc_pkg::CH_GT) begin
            run_bases = 0;
            skipping_header = 1'b1;
            flag = 1'b1;
        end else if (sym[6]) begin
            case (sym & khc_pkg::CH_CASE_MASK)
                khc_pkg::CH_A: code = khc_pkg::BASE_A;
                khc_pkg::CH_C: code = khc_pkg::BASE_C;
                khc_pkg::CH_G: code = khc_pkg::BASE_G;
                khc_pkg::CH_T: code = khc_pkg::BASE_T;
                default: code = -1;
            endcase
            if (code < 0) begin
                run_bases = 0;
            end else begin
                base_window = {base_window[2*MAX_K-3:0], 2'(code)};
                if (run_bases < MAX_K) run_bases++;
                if (all_len_reg) begin
                    top = (run_bases < k) ? run_bases : k;
                    for (int i = 1; i <= top; i++) bump_length(i);
                end else if (run_bases >= k) begin
                    bump_length(k);
                end
            end
        end
    endtask

    // Work out the result of one accepted request
    task automatic apply_request(input logic [1:0] act, input logic [31:0] data,
                                 output t_count_report rep);
        int len;
        int addr;
        logic flag;
        logic [khc_pkg::COUNT_BITS_DEF-1:0] cnt;
        len = clamp_length(data[11:8]);
        flag = 1'b0;
        rep.count_value = '0;
        case (act)
            khc_pkg::ACT_SEQ: feed_symbol(data[7:0], flag);
            khc_pkg::ACT_READ: begin
                addr = table_start(len) + (int'(data[27:12]) & ((1 << (2 * len)) - 1));
                cnt = counter_at(addr);
                rep.count_value = cnt[khc_pkg::COUNT_OUT_BITS-1:0];
            end
            khc_pkg::ACT_CLEAR: begin
                hist_counts.delete();
                for (int i = 0; i < MAX_K; i++) len_totals[i] = '0;
            end
            default: ;
        endcase
        rep.length_total = len_totals[len-1];
        rep.record_start = flag;
    endtask

    // Follow the channels: results first, since a result never belongs to this edge's request
    always @(posedge i_clk) begin
        t_count_report got;
        t_count_report want;
        if (!i_rst_n) begin
            hist_counts.delete();
            for (int i = 0; i < MAX_K; i++) len_totals[i] = '0;
            base_window = '0;
            run_bases = 0;
            skipping_header = 1'b0;
            kmer_len_reg = khc_pkg::KLEN_RESET;
            all_len_reg = 1'b0;
            reports_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.count_value = i_m_tdata[31:0];
                got.length_total = i_m_tdata[71:32];
                got.record_start = i_m_tuser[0];
                if (reports_due.size() == 0) begin
                    $error("unrequested result: count_value %0d, length_total %0d",
                           got.count_value, got.length_total);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (got.count_value !== want.count_value) begin
                        $error("count_value: expected %0d, actual %0d",
                               want.count_value, got.count_value);
                        mismatches++;
                    end
                    if (got.length_total !== want.length_total) begin
                        $error("length_total: expected %0d, actual %0d",
                               want.length_total, got.length_total);
                        mismatches++;
                    end
                    if (got.record_start !== want.record_start) begin
                        $error("record_start: expected %0d, actual %0d",
                               want.record_start, got.record_start);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == khc_pkg::CFG_KLEN) kmer_len_reg = i_cfg_data;
                else all_len_reg = i_cfg_data[0];
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tuser, i_s_tdata, want);
                reports_due = {reports_due, want};
            end
        end
        o_error_count <= mismatches;
        o_reports_due <= reports_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the k-mer histogram counter: stimulus, settings phases and verdict.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 2 * khc_pkg::MAX_K_DEF + 8;
    localparam int CHUNK_ITEMS = 125;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = khc_pkg::CFG_KLEN;
    logic [3:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = khc_pkg::ACT_SEQ;
    logic        i_m_tready = 1'b0;
    wire         o_cfg_ready;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [71:0] o_m_tdata;
    wire  [0:0]  o_m_tuser;

    int          error_count;
    int          reports_due;
    int          tx_idle_pct = 18;
    int          rx_idle_pct = 74;
    int          clear_budget = 0;
    int          cycle_count = 0;
    logic [15:0] base_trail = '0;

    kmer_histogram_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    khc_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .o_error_count (error_count),
        .o_reports_due (reports_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Write both registers back to back, then drop the request
    task automatic write_settings(input logic [3:0] klen, input logic all_flag);
        logic [2:0] pad;
        pad = 3'($urandom_range(7));
        i_cfg_valid <= 1'b1;
        i_cfg_index <= khc_pkg::CFG_KLEN;
        i_cfg_data <= klen;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= khc_pkg::CFG_ALL;
        i_cfg_data <= {pad, all_flag};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one request, after a random gap, and hold it until taken
    task automatic send_request(input logic [1:0] act, input logic [7:0] sym,
                                input logic [3:0] rlen, input logic [15:0] ridx);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {4'h0, ridx, rlen, sym};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Mostly legal lengths, now and then out of range
    function automatic logic [3:0] pick_length();
        if ($urandom_range(9) == 0) return 4'($urandom_range(15));
        return 4'($urandom_range(1, khc_pkg::MAX_K_DEF));
    endfunction

    task automatic send_byte(input logic [7:0] sym);
        send_request(khc_pkg::ACT_SEQ, sym, pick_length(), 16'($urandom_range(16'hFFFF)));
    endtask

    // Send a random base letter in either case and remember its code
    task automatic send_base();
        logic [1:0] code;
        logic [7:0] letter;
        code = 2'($urandom_range(3));
        case (code)
            khc_pkg::BASE_A: letter = khc_pkg::CH_A;
            khc_pkg::BASE_C: letter = khc_pkg::CH_C;
            khc_pkg::BASE_G: letter = khc_pkg::CH_G;
            default: letter = khc_pkg::CH_T;
        endcase
        if ($urandom_range(1) != 0) letter = letter | 8'h20;
        base_trail = {base_trail[13:0], code};
        send_byte(letter);
    endtask

    // Read mostly k-mers that were just sent, so counts are nonzero
    task automatic send_read();
        logic [15:0] idx;
        idx = ($urandom_range(99) < 60) ? base_trail : 16'($urandom_range(16'hFFFF));
        send_request(khc_pkg::ACT_READ, 8'($urandom_range(255)), pick_length(), idx);
    endtask

    // One item of a sequence line
    task automatic send_body_item();
        int pick;
        logic [7:0] sym;
        pick = $urandom_range(99);
        sym = 8'($urandom_range(255));
        if (pick < 72) begin
            send_base();
        end else if (pick < 78) begin
            send_byte(khc_pkg::CH_NL);
        end else if (pick < 82) begin
            sym[6] = 1'b1;
            send_byte(sym);
        end else if (pick < 92) begin
            send_read();
        end else if (pick < 94) begin
            send_request(ACT_NONE, sym, pick_length(), 16'($urandom_range(16'hFFFF)));
        end else begin
            send_byte(sym);
        end
    endtask

    // Any request at all; clears only while the budget lasts
    task automatic send_noise();
        logic [1:0] act;
        act = 2'($urandom_range(3));
        if (act == khc_pkg::ACT_CLEAR) begin
            if (clear_budget > 0 && $urandom_range(3) == 0) clear_budget--;
            else act = khc_pkg::ACT_READ;
        end
        send_request(act, 8'($urandom_range(255)), 4'($urandom_range(15)),
                     16'($urandom_range(16'hFFFF)));
    endtask

    // Mostly FASTA records with random content, the rest noise
    task automatic run_random_chunk(input int quota);
        int counted;
        int hdr_len;
        int body_len;
        logic [7:0] hdr_char;
        counted = 0;
        while (counted < quota) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(9) != 0) begin
                    send_byte(khc_pkg::CH_GT);
                    counted++;
                    hdr_len = $urandom_range(6);
                    repeat (hdr_len) begin
                        hdr_char = 8'($urandom_range(32, 126));
                        send_byte(hdr_char);
                    end
                    send_byte(khc_pkg::CH_NL);
                end
                body_len = $urandom_range(4, 30);
                repeat (body_len) begin
                    send_body_item();
                    counted++;
                end
            end else begin
                send_noise();
                counted++;
            end
        end
    endtask

    // Drop the request and wait until every result is back and the block is quiet
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (reports_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [3:0] klen;
        logic       all_flag;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_settings(4'd2, 1'b1);

        // Directed: fresh table, runs across newlines, header handling, reads, clear
        send_request(khc_pkg::ACT_READ, 8'h00, 4'd1, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_A, 4'd1, 16'hFFFF);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_C | 8'h20, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_NL, 4'd2, 16'h0000); // run goes on
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_G | 8'h20, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_T, 4'd1, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, 8'h4E, 4'd2, 16'h0000);         // N ends the run
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_T, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_GT, 4'd1, 16'h0000); // record start
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_A, 4'd1, 16'h0000);  // skipped
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_GT, 4'd1, 16'h0000); // no flag
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_NL, 4'd1, 16'h0000); // header ends
        send_request(khc_pkg::ACT_SEQ, 8'h00, 4'd0, 16'h0000);         // ignored byte
        send_request(khc_pkg::ACT_SEQ, 8'hFF, 4'd15, 16'hFFFF);        // not a base
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_C, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_A | 8'h20, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_READ, 8'hFF, 4'd2, 16'hFFF4);   // high index bits unused
        send_request(khc_pkg::ACT_READ, 8'h00, 4'd0, 16'h0000);   // length 0 acts as 1
        send_request(khc_pkg::ACT_READ, 8'h00, 4'd15, 16'hFFFF);  // length 15 acts as 8
        send_request(ACT_NONE, 8'hFF, 4'd2, 16'hFFFF);
        send_request(khc_pkg::ACT_CLEAR, 8'h00, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_READ, 8'h00, 4'd2, 16'h0004);
        send_request(khc_pkg::ACT_SEQ, khc_pkg::CH_T | 8'h20, 4'd2, 16'h0000);
        send_request(khc_pkg::ACT_READ, 8'h00, 4'd1, 16'h0003);
        drain_results();

        // Random phases over several settings and idle patterns
        for (int chunk = 0; chunk < 9; chunk++) begin
            case (chunk)
                0: begin klen = 4'd8;  all_flag = 1'b0; end
                1: begin klen = 4'd1;  all_flag = 1'b1; end
                2: begin klen = 4'd0;  all_flag = 1'b0; end
                3: begin klen = 4'd15; all_flag = 1'b1; end
                4: begin klen = 4'd3;  all_flag = 1'b0; end
                5: begin klen = 4'd8;  all_flag = 1'b1; end
                6: begin klen = 4'd1;  all_flag = 1'b0; end
                7: begin
                    klen = 4'($urandom_range(15));
                    all_flag = 1'($urandom_range(1));
                end
                default: begin klen = 4'd5; all_flag = 1'b1; end
            endcase
            tx_idle_pct = (chunk < 3) ? 18 : (chunk < 6) ? 74 : 0;
            rx_idle_pct = (chunk < 3) ? 74 : (chunk < 6) ? 18 : 0;
            clear_budget = (chunk == 2 || chunk == 5 || chunk == 7) ? 1 : 0;
            write_settings(klen, all_flag);
            run_random_chunk(CHUNK_ITEMS);
            drain_results();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
